// ----- hw/rtl/clt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and codes of the command-line token lexer.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam logic [2:0] TK_FLAG = 3'd0;
    localparam logic [2:0] TK_NUM  = 3'd1;
    localparam logic [2:0] TK_WORD = 3'd2;
    localparam logic [2:0] TK_STR  = 3'd3;
    localparam logic [2:0] TK_UNK  = 3'd4;
    localparam logic [2:0] TK_END  = 3'd5;

    localparam logic [0:0] KIND_DATA = 1'b0;
    localparam logic [0:0] KIND_EOI  = 1'b1;

    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [0:0] kind;
        logic [7:0] byte_value;
    } t_in;

    typedef struct packed {
        logic [2:0] token_kind;
        logic       has_char;
        logic [7:0] char_value;
        logic       last;
    } t_out;

    // results of one input byte: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        t_out       res0;
        t_out       res1;
    } t_step;

endpackage
`default_nettype wire

// ----- hw/rtl/clt_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clt_step
// Token mode register and per-byte decode into up to two result items.
// ----------------------------------------------------------------------------
module clt_step (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire clt_pkg::t_in   i_data,
    output clt_pkg::t_step      o_step
);

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_FLAG = 3'd1,
        MODE_NUM  = 3'd2,
        MODE_WORD = 3'd3,
        MODE_STR  = 3'd4
    } t_mode;

    typedef struct packed {
        logic         hit;
        clt_pkg::t_out res;
        t_mode        mode;
    } t_start;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alp(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic clt_pkg::t_out mk(input logic [2:0] k, input logic has,
                                         input logic [7:0] c, input logic lst);
        clt_pkg::t_out r;
        r.token_kind = k;
        r.has_char   = has;
        r.char_value = has ? c : 8'd0;
        r.last       = lst;
        return r;
    endfunction

    function automatic logic [2:0] close_kind(input t_mode m);
        logic [2:0] k;
        unique case (m)
            MODE_FLAG: k = clt_pkg::TK_FLAG;
            MODE_NUM:  k = clt_pkg::TK_NUM;
            MODE_WORD: k = clt_pkg::TK_WORD;
            default:   k = clt_pkg::TK_STR;
        endcase
        return k;
    endfunction

    function automatic t_start start_tok(input logic [7:0] c);
        t_start s;
        s.hit  = 1'b1;
        s.mode = MODE_IDLE;
        s.res  = mk(clt_pkg::TK_UNK, 1'b1, c, 1'b1);
        if (is_ws(c)) begin
            s.hit = 1'b0;
            s.res = '0;
        end else if (c == clt_pkg::CH_DASH) begin
            s.mode = MODE_FLAG;
            s.res  = mk(clt_pkg::TK_FLAG, 1'b1, c, 1'b0);
        end else if (is_dig(c)) begin
            s.mode = MODE_NUM;
            s.res  = mk(clt_pkg::TK_NUM, 1'b1, c, 1'b0);
        end else if (is_alp(c)) begin
            s.mode = MODE_WORD;
            s.res  = mk(clt_pkg::TK_WORD, 1'b1, c, 1'b0);
        end else if (c == clt_pkg::CH_QUOTE) begin
            s.hit  = 1'b0;
            s.mode = MODE_STR;
            s.res  = '0;
        end
        return s;
    endfunction

    t_mode      r_mode;
    t_mode      n_mode;
    t_start     st;
    logic [7:0] c;
    clt_pkg::t_out close_res;

    assign c         = i_data.byte_value;
    assign st        = start_tok(c);
    assign close_res = mk(close_kind(r_mode), 1'b0, 8'd0, 1'b1);

    always_comb begin
        n_mode = r_mode;
        o_step = '0;
        if (i_data.kind == clt_pkg::KIND_EOI) begin
            n_mode = MODE_IDLE;
            if (r_mode == MODE_FLAG || r_mode == MODE_NUM || r_mode == MODE_WORD
                    || r_mode == MODE_STR) begin
                o_step.count = 2'd2;
                o_step.res0  = close_res;
                o_step.res1  = mk(clt_pkg::TK_END, 1'b0, 8'd0, 1'b1);
            end else begin
                o_step.count = 2'd1;
                o_step.res0  = mk(clt_pkg::TK_END, 1'b0, 8'd0, 1'b1);
            end
        end else begin
            unique case (r_mode)
                MODE_FLAG: begin
                    o_step.count = 2'd1;
                    if (is_ws(c)) begin
                        o_step.res0 = close_res;
                        n_mode      = MODE_IDLE;
                    end else begin
                        o_step.res0 = mk(clt_pkg::TK_FLAG, 1'b1, c, 1'b0);
                    end
                end
                MODE_NUM: begin
                    if (is_dig(c) || c == clt_pkg::CH_DOT) begin
                        o_step.count = 2'd1;
                        o_step.res0  = mk(clt_pkg::TK_NUM, 1'b1, c, 1'b0);
                    end else begin
                        o_step.count = {st.hit, ~st.hit};
                        o_step.res0  = close_res;
                        o_step.res1  = st.res;
                        n_mode       = st.mode;
                    end
                end
                MODE_WORD: begin
                    if (is_alp(c) || is_dig(c) || c == clt_pkg::CH_UNDER
                            || c == clt_pkg::CH_DOT) begin
                        o_step.count = 2'd1;
                        o_step.res0  = mk(clt_pkg::TK_WORD, 1'b1, c, 1'b0);
                    end else begin
                        o_step.count = {st.hit, ~st.hit};
                        o_step.res0  = close_res;
                        o_step.res1  = st.res;
                        n_mode       = st.mode;
                    end
                end
                MODE_STR: begin
                    o_step.count = 2'd1;
                    if (c == clt_pkg::CH_QUOTE) begin
                        o_step.res0 = close_res;
                        n_mode      = MODE_IDLE;
                    end else begin
                        o_step.res0 = mk(clt_pkg::TK_STR, 1'b1, c, 1'b0);
                    end
                end
                default: begin
                    o_step.count = {1'b0, st.hit};
                    o_step.res0  = st.res;
                    n_mode       = st.mode;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
        end else if (i_accept) begin
            r_mode <= n_mode;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/cli_token_lexer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cli_token_lexer_top
// Streaming lexer: one byte in, tagged token bytes and close items out.
// latency: first result visible the cycle after the byte transfer
// throughput: one byte per cycle while the result queue holds at most two
//   entries and the receiver keeps up; a byte with two results needs an extra
//   output slot, which the four-entry result queue absorbs; input stalls
//   whenever the queue holds more than two entries, until results drain
// reset: synchronous active low, mode returns to idle and the queue empties
// ----------------------------------------------------------------------------
module cli_token_lexer_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire clt_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output clt_pkg::t_out       o_out_data
);

    localparam int AW = clt_pkg::FIFO_AW;
    localparam int CW = clt_pkg::FIFO_CW;

    clt_pkg::t_step step;
    clt_pkg::t_out  r_fifo [clt_pkg::FIFO_DEPTH];
    logic [AW-1:0]  r_wptr;
    logic [AW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;
    logic           accept;
    logic           pop;
    logic [CW-1:0]  push_n;

    assign o_in_ready  = r_count <= CW'(clt_pkg::FIFO_DEPTH - 2);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_count != '0;
    assign pop         = o_out_valid && i_out_ready;
    assign o_out_data  = r_fifo[r_rptr];
    assign push_n      = accept ? CW'(step.count) : '0;

    clt_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_in_data),
        .o_step   (step)
    );

    always_ff @(posedge i_clk) begin
        if (accept && step.count != 2'd0) begin
            r_fifo[r_wptr] <= step.res0;
        end
        if (accept && step.count == 2'd2) begin
            r_fifo[r_wptr + AW'(1)] <= step.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + AW'(push_n);
            r_count <= r_count + push_n - CW'(pop);
            if (pop) begin
                r_rptr <= r_rptr + AW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(clt_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != CW'(clt_pkg::FIFO_DEPTH) |-> r_wptr == r_rptr + AW'(r_count))
        else $error("queue pointers disagree with count");

    a_double_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && step.count == 2'd2 && !pop |=> r_count == $past(r_count) + CW'(2))
        else $error("double result not queued");

endmodule
`default_nettype wire

// ----- bench/cli_token_lexer_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cli_token_lexer_top_tb
// Self-checking bench for the streaming token lexer. A short directed stream
// covers every token class, the close and end items, empty strings and high
// bytes. It is followed by random streams of mostly well-formed tokens with
// noise. A scoreboard predicts every tagged byte and close item and checks the
// results in order, while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module cli_token_lexer_top_tb;

    localparam int NUM_ITEMS      = 1400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 150;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_FLAG,
        MODE_NUM,
        MODE_WORD,
        MODE_STR
    } t_lex_mode;

    class lexer_scoreboard;
        t_lex_mode     mode;
        clt_pkg::t_out token_queue[$];
        int            errors;

        function new();
            mode   = MODE_IDLE;
            errors = 0;
        endfunction

        static function bit is_space(logic [7:0] c);
            return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
        endfunction

        static function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        static function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function int pending();
            return token_queue.size();
        endfunction

        function void push_token(logic [2:0] kind, logic has, logic [7:0] c, logic lst);
            clt_pkg::t_out r;
            r.token_kind = kind;
            r.has_char   = has;
            r.char_value = has ? c : 8'h00;
            r.last       = lst;
            token_queue.insert(token_queue.size(), r);
        endfunction

        function void close_open_token();
            case (mode)
                MODE_FLAG: push_token(clt_pkg::TK_FLAG, 1'b0, 8'h00, 1'b1);
                MODE_NUM:  push_token(clt_pkg::TK_NUM, 1'b0, 8'h00, 1'b1);
                MODE_WORD: push_token(clt_pkg::TK_WORD, 1'b0, 8'h00, 1'b1);
                MODE_STR:  push_token(clt_pkg::TK_STR, 1'b0, 8'h00, 1'b1);
                default: ;
            endcase
            mode = MODE_IDLE;
        endfunction

        function void begin_token(logic [7:0] c);
            mode = MODE_IDLE;
            if (is_space(c)) begin
                return;
            end
            if (c == clt_pkg::CH_DASH) begin
                mode = MODE_FLAG;
                push_token(clt_pkg::TK_FLAG, 1'b1, c, 1'b0);
            end else if (is_digit(c)) begin
                mode = MODE_NUM;
                push_token(clt_pkg::TK_NUM, 1'b1, c, 1'b0);
            end else if (is_letter(c)) begin
                mode = MODE_WORD;
                push_token(clt_pkg::TK_WORD, 1'b1, c, 1'b0);
            end else if (c == clt_pkg::CH_QUOTE) begin
                mode = MODE_STR;
            end else begin
                push_token(clt_pkg::TK_UNK, 1'b1, c, 1'b1);
            end
        endfunction

        function void note_byte(clt_pkg::t_in it);
            logic [7:0] c;
            c = it.byte_value;
            if (it.kind == clt_pkg::KIND_EOI) begin
                close_open_token();
                push_token(clt_pkg::TK_END, 1'b0, 8'h00, 1'b1);
                return;
            end
            case (mode)
                MODE_FLAG: begin
                    if (is_space(c)) begin
                        close_open_token();
                    end else begin
                        push_token(clt_pkg::TK_FLAG, 1'b1, c, 1'b0);
                    end
                end
                MODE_NUM: begin
                    if (is_digit(c) || c == clt_pkg::CH_DOT) begin
                        push_token(clt_pkg::TK_NUM, 1'b1, c, 1'b0);
                    end else begin
                        close_open_token();
                        begin_token(c);
                    end
                end
                MODE_WORD: begin
                    if (is_letter(c) || is_digit(c) || c == clt_pkg::CH_UNDER
                            || c == clt_pkg::CH_DOT) begin
                        push_token(clt_pkg::TK_WORD, 1'b1, c, 1'b0);
                    end else begin
                        close_open_token();
                        begin_token(c);
                    end
                end
                MODE_STR: begin
                    if (c == clt_pkg::CH_QUOTE) begin
                        close_open_token();
                    end else begin
                        push_token(clt_pkg::TK_STR, 1'b1, c, 1'b0);
                    end
                end
                default: begin_token(c);
            endcase
        endfunction

        function void check_token(clt_pkg::t_out got);
            clt_pkg::t_out want;
            if (token_queue.size() == 0) begin
                $error("result with nothing expected: kind %0d char %02h", got.token_kind,
                       got.char_value);
                errors++;
                return;
            end
            want = token_queue.pop_front();
            if (got.token_kind !== want.token_kind) begin
                $error("token_kind mismatch: expected %0d, actual %0d", want.token_kind,
                       got.token_kind);
                errors++;
            end
            if (got.has_char !== want.has_char) begin
                $error("has_char mismatch: expected %0d, actual %0d", want.has_char,
                       got.has_char);
                errors++;
            end
            if (got.char_value !== want.char_value) begin
                $error("char_value mismatch: expected %02h, actual %02h", want.char_value,
                       got.char_value);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last mismatch: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    clt_pkg::t_in  i_in_data   = '0;
    logic          i_out_ready = 1'b0;
    logic          o_in_ready;
    logic          o_out_valid;
    clt_pkg::t_out o_out_data;

    lexer_scoreboard board = new();

    int items_sent   = 0;
    int burst_left   = 0;
    bit steady       = 1'b0;
    int hold_trigger = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int ready_style  = 0;
    int style_left   = 0;
    int idle_cycles  = 0;

    cli_token_lexer_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                board.note_byte(i_in_data);
            end
            if (o_out_valid && i_out_ready) begin
                board.check_token(o_out_data);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // receiver stall pattern, with long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_seen != hold_trigger) begin
            hold_seen   <= hold_trigger;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                ready_style <= $urandom_range(0, 3);
                style_left  <= $urandom_range(20, 200);
            end else begin
                style_left <= style_left - 1;
            end
            case (ready_style)
                0:       i_out_ready <= 1'b1;
                1:       i_out_ready <= 1'($urandom_range(0, 1));
                2:       i_out_ready <= ($urandom_range(0, 9) != 0);
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic offer(input clt_pkg::t_in it);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        if (!steady) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                         : $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic put_byte(input logic [7:0] b);
        clt_pkg::t_in it;
        it.kind       = clt_pkg::KIND_DATA;
        it.byte_value = b;
        offer(it);
    endtask

    task automatic put_eoi(input logic [7:0] b);
        clt_pkg::t_in it;
        it.kind       = clt_pkg::KIND_EOI;
        it.byte_value = b;
        offer(it);
    endtask

    task automatic put_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            put_byte(s[i]);
        end
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_space();
        int n;
        n = $urandom_range(0, 5);
        return (n == 5) ? 8'h20 : 8'(8'h09 + n);
    endfunction

    function automatic logic [7:0] pick_letter();
        logic [7:0] c;
        c = 8'($urandom_range(0, 25));
        return ($urandom_range(0, 1) == 0) ? "a" + c : "A" + c;
    endfunction

    function automatic logic [7:0] pick_word_char();
        case ($urandom_range(0, 5))
            0:       return pick_digit();
            1:       return clt_pkg::CH_UNDER;
            2:       return clt_pkg::CH_DOT;
            default: return pick_letter();
        endcase
    endfunction

    function automatic logic [7:0] pick_non_space();
        logic [7:0] c;
        do c = pick_byte(); while (lexer_scoreboard::is_space(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_non_quote();
        logic [7:0] c;
        do c = pick_byte(); while (c == clt_pkg::CH_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] pick_unknown();
        logic [7:0] c;
        do c = pick_byte();
        while (lexer_scoreboard::is_space(c) || lexer_scoreboard::is_digit(c)
               || lexer_scoreboard::is_letter(c) || c == clt_pkg::CH_DASH
               || c == clt_pkg::CH_QUOTE);
        return c;
    endfunction

    task automatic random_token();
        int sel;
        int n;
        int i;
        sel = $urandom_range(0, 99);
        if (sel < 16) begin
            put_byte(clt_pkg::CH_DASH);
            n = $urandom_range(0, 5);
            for (i = 0; i < n; i++) put_byte(pick_non_space());
            if ($urandom_range(0, 4) != 0) put_byte(pick_space());
        end else if (sel < 32) begin
            put_byte(pick_digit());
            n = $urandom_range(0, 5);
            for (i = 0; i < n; i++) begin
                put_byte(($urandom_range(0, 3) == 0) ? clt_pkg::CH_DOT : pick_digit());
            end
            if ($urandom_range(0, 1) == 0) put_byte(pick_space());
        end else if (sel < 50) begin
            put_byte(pick_letter());
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++) put_byte(pick_word_char());
            if ($urandom_range(0, 1) == 0) put_byte(pick_space());
        end else if (sel < 64) begin
            put_byte(clt_pkg::CH_QUOTE);
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++) put_byte(pick_non_quote());
            if ($urandom_range(0, 9) != 0) put_byte(clt_pkg::CH_QUOTE);
        end else if (sel < 72) begin
            put_byte(pick_unknown());
        end else if (sel < 82) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) put_byte(pick_space());
        end else if (sel < 97) begin
            put_byte(pick_byte());
        end else begin
            put_eoi(pick_byte());
        end
    endtask

    initial begin
        int holds_done;
        bit drained;
        holds_done = 0;
        drained    = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every class, close items, empty string, high and zero bytes, end of input
        put_text("-a\t1.9x_.\"\"\"q");
        put_byte(8'hff);
        put_byte(clt_pkg::CH_QUOTE);
        put_byte(8'h00);
        put_byte(8'h80);
        put_byte("7");
        put_eoi(8'h00);
        put_eoi(8'hff);
        put_byte(8'h0d);
        put_byte(clt_pkg::CH_QUOTE);
        put_byte("Z");
        put_eoi(8'h5a);

        while (items_sent < NUM_ITEMS) begin
            if (holds_done == 0 && items_sent >= 400) begin
                hold_trigger <= hold_trigger + 1;
                holds_done = 1;
                steady     = 1'b1;
            end else if (holds_done == 1 && items_sent >= 1100) begin
                hold_trigger <= hold_trigger + 1;
                holds_done = 2;
                steady     = 1'b1;
            end
            if (steady && ((items_sent >= 460 && items_sent < 1100) || items_sent >= 1160))
                    begin
                steady = 1'b0;
            end
            if (!drained && items_sent >= 800) begin
                wait_for_drain();
                drained = 1'b1;
            end
            random_token();
        end

        wait_for_drain();
        repeat (20) @(posedge i_clk);
        if (board.pending() != 0) begin
            $error("%0d expected results never arrived", board.pending());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
